// File: src/gn2o_pkg.sv
`timescale 1ns / 1ps

package gn2o_pkg;

   localparam int TABLE_SIZE  = 256;
   localparam int TBL_AW      = $clog2(TABLE_SIZE);
   localparam int MAX_OCTAVES = 8;
   localparam int OCT_W       = 4;
   localparam int COORD_W     = 24;
   localparam int FREQ_W      = 20;
   localparam int AMP_W       = 17;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int TOTAL_W     = 36;
   localparam int AMPSUM_W    = 20;
   localparam int VAL_W       = 16;

   localparam logic [FREQ_W-1:0] FREQ_ONE  = 20'd4096;
   localparam logic [FREQ_W-1:0] FREQ_MAX  = 20'hFFFFF;
   localparam logic [AMP_W-1:0]  AMP_ONE   = 17'd65536;
   localparam logic [16:0]       FADE_ONE  = 17'd65536;
   localparam logic signed [17:0] ONE_Q16  = 18'sd65536;
   localparam logic signed [35:0] HALF_SQRT2_Q16   = 36'sd46341;
   localparam logic signed [36:0] SEVEN_TENTHS_Q16 = 37'sd45875;
   localparam logic signed [VAL_W-1:0] CLAMP_POS = 16'sd32767;
   localparam logic signed [VAL_W-1:0] CLAMP_NEG = -16'sd32767;

   localparam logic [CSR_IDX_W-1:0] CSR_OCTAVE_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PERSISTENCE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LACUNARITY   = 2'd2;

   localparam logic [OCT_W-1:0]  OCT_RESET  = 4'd4;
   localparam logic [15:0]       PERS_RESET = 16'd32768;
   localparam logic [15:0]       LAC_RESET  = 16'd8192;

   typedef enum logic {KIND_LOAD, KIND_EVAL} item_kind_type;

   typedef struct packed {
      item_kind_type      kind;
      logic [TBL_AW-1:0]  table_index;
      logic [7:0]         table_value;
      logic [COORD_W-1:0] x_coord;
      logic [COORD_W-1:0] y_coord;
   } item_type;

   typedef struct packed {
      logic [OCT_W-1:0] octave_count;
      logic [15:0]      persistence;
      logic [15:0]      lacunarity;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SCALE, ST_T2, ST_T3, ST_FADE, ST_DOTB,
      ST_LERPX, ST_LERPY, ST_OUTSC, ST_ACC, ST_DIV, ST_DONE
   } back_state_type;

   // gradient dot product; odd hashes use the diagonal gradients
   function automatic logic signed [19:0] corner_dot(input logic [2:0] h,
                                                     input logic signed [17:0] dx,
                                                     input logic signed [17:0] dy);
      logic signed [19:0] ex;
      logic signed [19:0] ey;
      logic signed [19:0] s;
      logic signed [35:0] p;
      ex = {{2{dx[17]}}, dx};
      ey = {{2{dy[17]}}, dy};
      s  = '0;
      case (h)
         3'd1:    s = ex + ey;
         3'd3:    s = ey - ex;
         3'd5:    s = -(ex + ey);
         3'd7:    s = ex - ey;
         default: s = '0;
      endcase
      p = {{16{s[19]}}, s} * HALF_SQRT2_Q16;
      case (h)
         3'd0:    corner_dot = ex;
         3'd2:    corner_dot = ey;
         3'd4:    corner_dot = -ex;
         3'd6:    corner_dot = -ey;
         default: corner_dot = p[35:16];
      endcase
   endfunction

   function automatic logic signed [19:0] blend(input logic [16:0] t,
                                                input logic signed [19:0] a,
                                                input logic signed [19:0] b);
      logic signed [20:0] d;
      logic signed [38:0] p;
      logic signed [22:0] sum;
      d   = {b[19], b} - {a[19], a};
      p   = $signed({22'b0, t}) * {{18{d[20]}}, d};
      sum = {{3{a[19]}}, a} + p[38:16];
      blend = sum[19:0];
   endfunction

endpackage

// File: src/gn2o_front.sv
`timescale 1ns / 1ps

module gn2o_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_mode,
   input  logic [gn2o_pkg::TBL_AW-1:0]    req_table_index,
   input  logic [7:0]                     req_table_value,
   input  logic [gn2o_pkg::COORD_W-1:0]   req_x_coord,
   input  logic [gn2o_pkg::COORD_W-1:0]   req_y_coord,
   output logic                           q_valid,
   output gn2o_pkg::item_type             q_item,
   input  logic                           q_pop
);

   gn2o_pkg::item_type entry_ff [2];
   gn2o_pkg::item_type new_item;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;

   always_comb begin
      new_item.kind        = req_mode ? gn2o_pkg::KIND_EVAL : gn2o_pkg::KIND_LOAD;
      new_item.table_index = req_table_index;
      new_item.table_value = req_table_value;
      new_item.x_coord     = req_x_coord;
      new_item.y_coord     = req_y_coord;
   end

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

// File: src/gn2o_div.sv
`timescale 1ns / 1ps

module gn2o_div (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic signed [gn2o_pkg::TOTAL_W-1:0]   dividend,
   input  logic [gn2o_pkg::AMPSUM_W-1:0]         divisor,
   output logic                                  done,
   output logic signed [gn2o_pkg::VAL_W-1:0]     quotient
);

   localparam int QW = gn2o_pkg::VAL_W;

   logic [gn2o_pkg::TOTAL_W-1:0] rem_ff, rem_in;
   logic [gn2o_pkg::TOTAL_W-1:0] dsh_ff, dsh_in;
   logic [QW-1:0]                q_ff, q_in;
   logic                         neg_ff, neg_in;
   logic [4:0]                   cnt_ff, cnt_in;
   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic signed [QW:0]           sq;

   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         neg_in  = dividend[gn2o_pkg::TOTAL_W-1];
         rem_in  = dividend[gn2o_pkg::TOTAL_W-1] ? 36'(-dividend) : 36'(dividend);
         dsh_in  = {1'b0, divisor, 15'b0};
         q_in    = '0;
         cnt_in  = 5'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // one quotient bit a cycle
         if (rem_ff >= dsh_ff) begin
            rem_in = rem_ff - dsh_ff;
            q_in   = {q_ff[QW-2:0], 1'b1};
         end else begin
            q_in   = {q_ff[QW-2:0], 1'b0};
         end
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(QW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 5'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
      neg_ff <= neg_in;
   end

   always_comb begin
      sq = (q_ff > 16'd32767) ? 17'sd32767 : $signed({1'b0, q_ff});
      if (neg_ff) begin
         sq = -sq;
      end
      quotient = sq[QW-1:0];
   end

   assign done = done_ff;

endmodule

// File: src/gn2o_back.sv
`timescale 1ns / 1ps

module gn2o_back (
   input  logic                                clock,
   input  logic                                reset,
   input  gn2o_pkg::cfg_type                   cfg,
   input  logic                                q_valid,
   input  gn2o_pkg::item_type                  q_item,
   output logic                                q_pop,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [gn2o_pkg::VAL_W-1:0]   rsp_noise_value
);

   localparam int AW = gn2o_pkg::TBL_AW;

   gn2o_pkg::back_state_type state_ff, state_in;

   logic [7:0] tbl [gn2o_pkg::TABLE_SIZE];
   logic [AW-1:0] addr_a, addr_b;
   logic [7:0]    rd_a_ff, rd_b_ff;
   logic          tbl_we;

   logic [gn2o_pkg::COORD_W-1:0] x_ff, y_ff, sx_ff, sy_ff;
   logic [gn2o_pkg::FREQ_W-1:0]  freq_ff;
   logic [gn2o_pkg::AMP_W-1:0]   amp_ff, amp_cur_ff;
   logic [gn2o_pkg::AMPSUM_W-1:0] amp_sum_ff;
   logic signed [gn2o_pkg::TOTAL_W-1:0] total_ff;
   logic [gn2o_pkg::OCT_W-1:0]   oct_n_ff, oct_cnt_ff, oct_n_new;
   logic [15:0] t2x_ff, t2y_ff, t3x_ff, t3y_ff;
   logic [20:0] inx_ff, iny_ff;
   logic [16:0] u_ff, v_ff;
   logic [7:0]  pxn_ff;
   logic signed [19:0] d_aa_ff, d_ab_ff, d_ba_ff, d_bb_ff, r0_ff, r1_ff, r_ff;
   logic signed [gn2o_pkg::VAL_W-1:0] oct_val_ff;
   logic signed [gn2o_pkg::VAL_W-1:0] result_ff;

   logic rsp_valid_ff;
   logic signed [gn2o_pkg::VAL_W-1:0] rsp_value_ff;

   logic        div_start, div_done, out_load, last_oct;
   logic signed [gn2o_pkg::VAL_W-1:0] div_q;

   // scaled coordinate pieces
   logic [15:0] tx, ty;
   logic [AW-1:0] xi, yi;
   logic signed [17:0] dx0, dy0, dx1, dy1;

   assign tx  = sx_ff[15:0];
   assign ty  = sy_ff[15:0];
   assign xi  = sx_ff[16 +: AW];
   assign yi  = sy_ff[16 +: AW];
   assign dx0 = $signed({2'b0, tx});
   assign dy0 = $signed({2'b0, ty});
   assign dx1 = dx0 - gn2o_pkg::ONE_Q16;
   assign dy1 = dy0 - gn2o_pkg::ONE_Q16;

   assign oct_n_new = (cfg.octave_count > 4'(gn2o_pkg::MAX_OCTAVES))
                      ? 4'(gn2o_pkg::MAX_OCTAVES) : cfg.octave_count;
   assign last_oct  = (4'(oct_cnt_ff + 4'd1) == oct_n_ff);
   assign out_load  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in  = state_ff;
      q_pop     = 1'b0;
      tbl_we    = 1'b0;
      addr_a    = xi;
      addr_b    = AW'(xi + 1'b1);
      unique case (state_ff)
         gn2o_pkg::ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_item.kind == gn2o_pkg::KIND_LOAD) begin
                  tbl_we = 1'b1;
               end else if (oct_n_new == '0) begin
                  state_in = gn2o_pkg::ST_DONE;
               end else begin
                  state_in = gn2o_pkg::ST_SCALE;
               end
            end
         end
         gn2o_pkg::ST_SCALE: state_in = gn2o_pkg::ST_T2;
         gn2o_pkg::ST_T2:    state_in = gn2o_pkg::ST_T3;
         gn2o_pkg::ST_T3: begin
            addr_a   = AW'(rd_a_ff[AW-1:0] + yi);
            addr_b   = AW'(rd_a_ff[AW-1:0] + yi + 1'b1);
            state_in = gn2o_pkg::ST_FADE;
         end
         gn2o_pkg::ST_FADE: begin
            addr_a   = AW'(pxn_ff[AW-1:0] + yi);
            addr_b   = AW'(pxn_ff[AW-1:0] + yi + 1'b1);
            state_in = gn2o_pkg::ST_DOTB;
         end
         gn2o_pkg::ST_DOTB:  state_in = gn2o_pkg::ST_LERPX;
         gn2o_pkg::ST_LERPX: state_in = gn2o_pkg::ST_LERPY;
         gn2o_pkg::ST_LERPY: state_in = gn2o_pkg::ST_OUTSC;
         gn2o_pkg::ST_OUTSC: state_in = gn2o_pkg::ST_ACC;
         gn2o_pkg::ST_ACC: begin
            if (last_oct) begin
               state_in = gn2o_pkg::ST_DIV;
            end else begin
               state_in = gn2o_pkg::ST_SCALE;
            end
         end
         gn2o_pkg::ST_DIV: begin
            if (div_done) begin
               state_in = gn2o_pkg::ST_DONE;
            end
         end
         gn2o_pkg::ST_DONE: begin
            if (out_load) begin
               state_in = gn2o_pkg::ST_IDLE;
            end
         end
         default: state_in = gn2o_pkg::ST_IDLE;
      endcase
   end

   // total settles in ACC, so start the divider in the cycle after it
   logic div_go_ff;
   assign div_start = div_go_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gn2o_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         div_go_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         div_go_ff <= (state_ff == gn2o_pkg::ST_ACC) && last_oct;
         if (state_ff == gn2o_pkg::ST_DONE && out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == gn2o_pkg::ST_DONE && out_load) begin
         rsp_value_ff <= result_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl[q_item.table_index] <= q_item.table_value;
      end
      rd_a_ff <= tbl[addr_a];
      rd_b_ff <= tbl[addr_b];
   end

   logic [43:0] px_prod, py_prod;
   logic [32:0] amp_prod;
   logic [35:0] freq_prod;
   logic [31:0] t2x_prod, t2y_prod, t3x_prod, t3y_prod;
   logic [36:0] fx_prod, fy_prod;
   logic [20:0] fx, fy;
   logic signed [36:0] sc_prod;
   logic signed [19:0] sc;
   logic signed [33:0] acc_prod;

   always_comb begin
      px_prod   = {20'b0, x_ff} * {24'b0, freq_ff};
      py_prod   = {20'b0, y_ff} * {24'b0, freq_ff};
      amp_prod  = {16'b0, amp_ff} * {17'b0, cfg.persistence};
      freq_prod = {16'b0, freq_ff} * {20'b0, cfg.lacunarity};
      t2x_prod  = {16'b0, tx} * {16'b0, tx};
      t2y_prod  = {16'b0, ty} * {16'b0, ty};
      t3x_prod  = {16'b0, t2x_ff} * {16'b0, tx};
      t3y_prod  = {16'b0, t2y_ff} * {16'b0, ty};
      fx_prod   = {21'b0, t3x_ff} * {16'b0, inx_ff};
      fy_prod   = {21'b0, t3y_ff} * {16'b0, iny_ff};
      fx        = fx_prod[36:16];
      fy        = fy_prod[36:16];
      sc_prod   = {{17{r_ff[19]}}, r_ff} * gn2o_pkg::SEVEN_TENTHS_Q16;
      sc        = sc_prod[36:17];
      acc_prod  = {{18{oct_val_ff[15]}}, oct_val_ff} * $signed({17'b0, amp_cur_ff});
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         gn2o_pkg::ST_IDLE: begin
            x_ff       <= q_item.x_coord;
            y_ff       <= q_item.y_coord;
            oct_n_ff   <= oct_n_new;
            oct_cnt_ff <= '0;
            freq_ff    <= gn2o_pkg::FREQ_ONE;
            amp_ff     <= gn2o_pkg::AMP_ONE;
            amp_sum_ff <= '0;
            total_ff   <= '0;
            result_ff  <= '0;
         end
         gn2o_pkg::ST_SCALE: begin
            sx_ff      <= px_prod[35:12];
            sy_ff      <= py_prod[35:12];
            amp_cur_ff <= amp_ff;
            amp_sum_ff <= amp_sum_ff + 20'(amp_ff);
            amp_ff     <= amp_prod[32:16];
            // saturate the running frequency
            if (freq_prod[35:12] > 24'(gn2o_pkg::FREQ_MAX)) begin
               freq_ff <= gn2o_pkg::FREQ_MAX;
            end else begin
               freq_ff <= freq_prod[31:12];
            end
         end
         gn2o_pkg::ST_T2: begin
            t2x_ff <= t2x_prod[31:16];
            t2y_ff <= t2y_prod[31:16];
         end
         gn2o_pkg::ST_T3: begin
            t3x_ff <= t3x_prod[31:16];
            t3y_ff <= t3y_prod[31:16];
            inx_ff <= 21'(t2x_ff) * 21'd6 + 21'd655360 - 21'(tx) * 21'd15;
            iny_ff <= 21'(t2y_ff) * 21'd6 + 21'd655360 - 21'(ty) * 21'd15;
            pxn_ff <= rd_b_ff;
         end
         gn2o_pkg::ST_FADE: begin
            u_ff    <= (fx > 21'(gn2o_pkg::FADE_ONE)) ? gn2o_pkg::FADE_ONE : fx[16:0];
            v_ff    <= (fy > 21'(gn2o_pkg::FADE_ONE)) ? gn2o_pkg::FADE_ONE : fy[16:0];
            d_aa_ff <= gn2o_pkg::corner_dot(rd_a_ff[2:0], dx0, dy0);
            d_ab_ff <= gn2o_pkg::corner_dot(rd_b_ff[2:0], dx0, dy1);
         end
         gn2o_pkg::ST_DOTB: begin
            d_ba_ff <= gn2o_pkg::corner_dot(rd_a_ff[2:0], dx1, dy0);
            d_bb_ff <= gn2o_pkg::corner_dot(rd_b_ff[2:0], dx1, dy1);
         end
         gn2o_pkg::ST_LERPX: begin
            r0_ff <= gn2o_pkg::blend(u_ff, d_aa_ff, d_ba_ff);
            r1_ff <= gn2o_pkg::blend(u_ff, d_ab_ff, d_bb_ff);
         end
         gn2o_pkg::ST_LERPY: begin
            r_ff <= gn2o_pkg::blend(v_ff, r0_ff, r1_ff);
         end
         gn2o_pkg::ST_OUTSC: begin
            if (sc > 20'sd32767) begin
               oct_val_ff <= gn2o_pkg::CLAMP_POS;
            end else if (sc < -20'sd32767) begin
               oct_val_ff <= gn2o_pkg::CLAMP_NEG;
            end else begin
               oct_val_ff <= sc[15:0];
            end
         end
         gn2o_pkg::ST_ACC: begin
            total_ff   <= total_ff + {{2{acc_prod[33]}}, acc_prod};
            oct_cnt_ff <= oct_cnt_ff + 4'd1;
         end
         gn2o_pkg::ST_DIV: begin
            if (div_done) begin
               result_ff <= div_q;
            end
         end
         default: ;
      endcase
   end

   gn2o_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (total_ff),
      .divisor  (amp_sum_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_noise_value = rsp_value_ff;

endmodule

// File: src/gradient_noise_2d_octaves_unit.sv
`timescale 1ns / 1ps
// Load items are written to the table as they are popped. Evaluate items go from
// the queue head to the result register through a pop, nine sequencer steps for
// each of N octaves (N = octaves used, at most 8), the bit-serial divider (start,
// 16 quotient bits, hand-back) and an output step; zero octaves skip to it.
// One item is in the back end at a time; a two-entry queue holds those waiting.
// Synchronous active-high reset clears control and restores the register defaults.

module gradient_noise_2d_octaves_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_mode,
   input  logic [7:0]                            req_table_index,
   input  logic [7:0]                            req_table_value,
   input  logic [23:0]                           req_x_coord,
   input  logic [23:0]                           req_y_coord,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [15:0]                    rsp_noise_value,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [gn2o_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [gn2o_pkg::CSR_DATA_W-1:0]       csr_data
);

   gn2o_pkg::cfg_type  cfg_ff;
   gn2o_pkg::item_type q_item;
   logic               q_valid, q_pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.octave_count <= gn2o_pkg::OCT_RESET;
         cfg_ff.persistence  <= gn2o_pkg::PERS_RESET;
         cfg_ff.lacunarity   <= gn2o_pkg::LAC_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            gn2o_pkg::CSR_OCTAVE_COUNT: cfg_ff.octave_count <= csr_data[gn2o_pkg::OCT_W-1:0];
            gn2o_pkg::CSR_PERSISTENCE:  cfg_ff.persistence  <= csr_data;
            gn2o_pkg::CSR_LACUNARITY:   cfg_ff.lacunarity   <= csr_data;
            default: ;
         endcase
      end
   end

   gn2o_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_table_index (req_table_index),
      .req_table_value (req_table_value),
      .req_x_coord     (req_x_coord),
      .req_y_coord     (req_y_coord),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_pop           (q_pop)
   );

   gn2o_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_noise_value (rsp_noise_value)
   );

endmodule
